[hw/rtl/mpc_pkg.sv]
// Shared types and constants for the matrix product column engine.
// No dependencies; imported by the controller, the datapath and the top level.
package mpc_pkg;

    // Default for the largest supported matrix dimension.
    localparam int MAX_DIM_DEF = 16;

    // Widths fixed by the transaction fields and registers.
    localparam int ACTION_W = 2;
    localparam int IDX_W    = 4;
    localparam int ELEM_W   = 16;
    localparam int ACC_W    = 32;
    localparam int DIM_W    = 5;
    localparam int CFG_IDX_W = 2;

    // Action codes of an input transaction.
    localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic issue;     // issue one multiply-accumulate term
        logic row_next;  // advance to the next row of A
        logic out_load;  // move the finished sum into the output register
    } mpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_ok;    // pending input is a compute on a valid column
        logic last_inner;  // the term being issued is the last of the row
        logic last_row;    // the current row is the last row of A
        logic row_done;    // the accumulator holds a finished row sum
        logic out_free;    // the output register can take a new result
    } mpc_status_t;

endpackage

[hw/rtl/mpc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/mpc_ctrl.sv]
// Controller state machine for the matrix product column engine.
// Depends on mpc_pkg; drives the datapath through mpc_cmd_t.
module mpc_ctrl
    import mpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mpc_status_t status,
    output mpc_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.start_ok) begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (status.last_inner) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.row_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.last_row) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.row_next = 1'b1;
                        state_next   = ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A finished row sum must arrive only while the controller waits for it.
    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        status.row_done |-> state_reg == ST_DRAIN)
        else $error("row sum finished outside the drain state");

    // A result is never loaded over one that has not been taken.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    // The last term of a row is followed by the drain state.
    a_issue_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE && status.last_inner) |=> state_reg == ST_DRAIN)
        else $error("issue did not stop after the last term");

    // No new input is taken while a row is in flight.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue || state_reg == ST_DRAIN) |-> !s_ready)
        else $error("input accepted during a compute");

endmodule

[hw/rtl/mpc_datapath.sv]
// Datapath: configuration registers, A and B stores, counters, the shared
// multiply-accumulate pipeline and the output register. Depends on mpc_pkg
// and mpc_ram.
module mpc_datapath
    import mpc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DIM_W-1:0]           cfg_wr_data,
    input  logic [ACTION_W-1:0]        s_action,
    input  logic [IDX_W-1:0]           s_row_index,
    input  logic [IDX_W-1:0]           s_col_index,
    input  logic signed [ELEM_W-1:0]   s_element_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [IDX_W-1:0]           m_out_row,
    output logic signed [ACC_W-1:0]    m_product_value,
    output logic                       m_last_of_column,
    input  mpc_cmd_t                   cmd,
    output mpc_status_t                status
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'((MAX_DIM < 16) ? MAX_DIM : 16);

    // Registers out of range: zero acts as one, above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_size_reg;
    logic [DIM_W-1:0] cols_b_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg     <= DIM_RESET;
            inner_size_reg <= DIM_RESET;
            cols_b_reg     <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROWS_A:     rows_a_reg     <= clamp_dim(cfg_wr_data);
                CFG_INNER_SIZE: inner_size_reg <= clamp_dim(cfg_wr_data);
                CFG_COLS_B:     cols_b_reg     <= clamp_dim(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // Load decode with bounds checks.
    logic              load_a_ok;
    logic              load_b_ok;
    logic [ADDR_W-1:0] load_addr;

    assign load_a_ok = cmd.accept && s_action == ACT_LOAD_A
        && DIM_W'(s_row_index) < rows_a_reg && DIM_W'(s_col_index) < inner_size_reg;
    assign load_b_ok = cmd.accept && s_action == ACT_LOAD_B
        && DIM_W'(s_row_index) < inner_size_reg && DIM_W'(s_col_index) < cols_b_reg;
    assign load_addr = ADDR_W'(32'(s_row_index) * MAX_DIM + 32'(s_col_index));

    // Row, term and column counters.
    logic [DIM_W-1:0] row_cnt_reg;
    logic [DIM_W-1:0] inner_cnt_reg;
    logic [IDX_W-1:0] col_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            row_cnt_reg   <= '0;
            inner_cnt_reg <= '0;
            col_reg       <= s_col_index;
        end else begin
            if (cmd.issue) begin
                inner_cnt_reg <= status.last_inner ? '0 : inner_cnt_reg + 1'b1;
            end
            if (cmd.row_next) begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
        end
    end

    // Read addresses of the current term.
    logic [ADDR_W-1:0] a_rd_addr;
    logic [ADDR_W-1:0] b_rd_addr;
    logic [ELEM_W-1:0] a_rd_data;
    logic [ELEM_W-1:0] b_rd_data;

    assign a_rd_addr = ADDR_W'(32'(row_cnt_reg) * MAX_DIM + 32'(inner_cnt_reg));
    assign b_rd_addr = ADDR_W'(32'(inner_cnt_reg) * MAX_DIM + 32'(col_reg));

    mpc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .aclk    (aclk),
        .wr_en   (load_a_ok),
        .wr_addr (load_addr),
        .wr_data (s_element_value),
        .rd_en   (cmd.issue),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mpc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .aclk    (aclk),
        .wr_en   (load_b_ok),
        .wr_addr (load_addr),
        .wr_data (s_element_value),
        .rd_en   (cmd.issue),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // Term markers follow the store read, the multiply and the accumulate.
    logic v1_reg, first1_reg, last1_reg;
    logic v2_reg, first2_reg, last2_reg;
    logic row_done_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            row_done_reg <= 1'b0;
        end else begin
            v1_reg       <= cmd.issue;
            v2_reg       <= v1_reg;
            row_done_reg <= v2_reg && last2_reg;
        end
    end

    // Multiply, then accumulate with 32-bit wrap.
    always_ff @(posedge aclk) begin
        first1_reg <= inner_cnt_reg == '0;
        last1_reg  <= status.last_inner;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        prod_reg   <= ACC_W'($signed(a_rd_data)) * ACC_W'($signed(b_rd_data));
        if (v2_reg) begin
            acc_reg <= first2_reg ? prod_reg : acc_reg + prod_reg;
        end
    end

    // Output register.
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_out_row        <= row_cnt_reg[IDX_W-1:0];
            m_product_value  <= acc_reg;
            m_last_of_column <= status.last_row;
        end
    end

    assign m_valid = m_valid_reg;

    // Status to the controller.
    always_comb begin
        status.start_ok   = s_action == ACT_COMPUTE && DIM_W'(s_col_index) < cols_b_reg;
        status.last_inner = inner_cnt_reg == inner_size_reg - 1'b1;
        status.last_row   = row_cnt_reg == rows_a_reg - 1'b1;
        status.row_done   = row_done_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

endmodule

[hw/rtl/matrix_product_column_top.sv]
// Top level of the matrix product column engine: controller plus datapath.
// Depends on mpc_pkg, mpc_ctrl, mpc_datapath (and mpc_ram below it).
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    action, row_index, col_index, element_value
//  m_       out        m_valid / m_ready    out_row, product_value, last_of_column
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wr_data
//
// A load transaction is written into its store when its indexes are in range. A
// compute transaction is accepted and then runs row by row through the single shared
// multiply-accumulate unit fed one term per cycle from the two stores.
// Reset is synchronous and active low; store contents are not cleared.
// A stalled output holds the engine in the emit step until the result is taken.
module matrix_product_column_top
    import mpc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DIM_W-1:0]         cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACTION_W-1:0]      s_action,
    input  logic [IDX_W-1:0]         s_row_index,
    input  logic [IDX_W-1:0]         s_col_index,
    input  logic signed [ELEM_W-1:0] s_element_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_W-1:0]         m_out_row,
    output logic signed [ACC_W-1:0]  m_product_value,
    output logic                     m_last_of_column
);

    mpc_cmd_t    cmd;
    mpc_status_t status;

    mpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mpc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_action         (s_action),
        .s_row_index      (s_row_index),
        .s_col_index      (s_col_index),
        .s_element_value  (s_element_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_row        (m_out_row),
        .m_product_value  (m_product_value),
        .m_last_of_column (m_last_of_column),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
